/* sv/afd_pkg.sv */
// Shared types, codes and decode constants for the fault address decoder.
`timescale 1ns / 1ps
`default_nettype none
package afd_pkg;

    localparam int REG_COUNT       = 16;
    localparam int REG_IDX_W       = 4;
    localparam int AFD_QUEUE_DEPTH = 4;

    localparam logic OPC_WRITE  = 1'b0;
    localparam logic OPC_DECODE = 1'b1;

    localparam logic [REG_IDX_W-1:0] REG_SP = 4'd13;
    localparam logic [REG_IDX_W-1:0] REG_PC = 4'd15;

    // offset source
    localparam logic [1:0] OFF_IMM = 2'd0;
    localparam logic [1:0] OFF_REG = 2'd1;
    localparam logic [1:0] OFF_SHF = 2'd2;

    // shifter types
    localparam logic [1:0] SH_LSL = 2'd0;
    localparam logic [1:0] SH_LSR = 2'd1;
    localparam logic [1:0] SH_ASR = 2'd2;
    localparam logic [1:0] SH_ROR = 2'd3;

    localparam logic [7:0] SH_CTL_BYPASS = 8'h0B;

    localparam logic [31:0] ARM_SWP_MASK  = 32'h0FB00FF0;
    localparam logic [31:0] ARM_SWP_MATCH = 32'h01000090;
    localparam logic [31:0] ARM_LS_MASK   = 32'h0C000000;
    localparam logic [31:0] ARM_LS_MATCH  = 32'h04000000;
    localparam logic [31:0] ARM_HW_MASK   = 32'h0E400F90;
    localparam logic [31:0] ARM_HWR_MATCH = 32'h00000090;
    localparam logic [31:0] ARM_HWI_MATCH = 32'h00400090;
    localparam logic [31:0] ARM_BLK_MASK  = 32'h0E000000;
    localparam logic [31:0] ARM_BLK_MATCH = 32'h08000000;

    localparam logic [15:0] TH_LDPC_MASK  = 16'hF800;
    localparam logic [15:0] TH_LDPC_MATCH = 16'h4800;
    localparam logic [15:0] TH_RR_MASK    = 16'hF200;
    localparam logic [15:0] TH_RR_MATCH   = 16'h5000;
    localparam logic [15:0] TH_RRH_MATCH  = 16'h5200;
    localparam logic [15:0] TH_IMW_MASK   = 16'hE000;
    localparam logic [15:0] TH_IMW_MATCH  = 16'h6000;
    localparam logic [15:0] TH_NIB_MASK   = 16'hF000;
    localparam logic [15:0] TH_IMH_MATCH  = 16'h8000;
    localparam logic [15:0] TH_SPR_MATCH  = 16'h9000;
    localparam logic [15:0] TH_PUSH_MASK  = 16'hF700;
    localparam logic [15:0] TH_PUSH_MATCH = 16'hB500;
    localparam logic [15:0] TH_LDM_MATCH  = 16'hC000;

    // one classified word between the front and the back
    typedef struct packed {
        logic                 is_write;
        logic                 hit;
        logic [REG_IDX_W-1:0] ra;
        logic [REG_IDX_W-1:0] rb;
        logic [REG_IDX_W-1:0] rs;
        logic                 use_rs;
        logic [1:0]           off_sel;
        logic [31:0]          imm;
        logic                 add;
        logic [1:0]           sh_type;
        logic [4:0]           sh_imm;
        logic                 sh_bypass;
    } t_afd_op;

endpackage
`default_nettype wire

/* sv/afd_in_if.sv */
// Input channel: register writes and instruction words.
`timescale 1ns / 1ps
`default_nettype none
interface afd_in_if;
    logic        valid;
    logic        ready;
    logic        opcode;
    logic [3:0]  reg_index;
    logic [31:0] reg_value;
    logic [31:0] instruction;
    logic        thumb;

    modport source (output valid, output opcode, output reg_index, output reg_value,
                    output instruction, output thumb, input ready);
    modport sink   (input valid, input opcode, input reg_index, input reg_value,
                    input instruction, input thumb, output ready);
endinterface
`default_nettype wire

/* sv/afd_out_if.sv */
// Output channel: decoded access address and match flag.
`timescale 1ns / 1ps
`default_nettype none
interface afd_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] address;
    logic        matched;

    modport source (output valid, output address, output matched, input ready);
    modport sink   (input valid, input address, input matched, output ready);
endinterface
`default_nettype wire

/* sv/afd_front.sv */
// Front end: accept words and classify instruction patterns into operand selects.
`timescale 1ns / 1ps
`default_nettype none
module afd_front (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    afd_in_if.sink          i_in,
    output afd_pkg::t_afd_op o_push_data,
    output logic            o_push_valid,
    input  wire logic       i_push_ready
);
    import afd_pkg::*;

    logic    r_vld;
    t_afd_op r_op;
    t_afd_op n_op;
    logic    take;
    logic [15:0] th;
    logic [31:0] w;
    logic [31:0] th_sext;

    assign w       = i_in.instruction;
    assign th      = i_in.instruction[15:0];
    assign th_sext = {{24{th[7]}}, th[7:0]};

    assign i_in.ready = !r_vld || i_push_ready;
    assign take       = i_in.valid && i_in.ready;

    always_comb begin
        n_op           = '0;
        n_op.add       = 1'b1;
        n_op.off_sel   = OFF_IMM;
        n_op.sh_type   = SH_LSL;
        if (i_in.opcode == OPC_WRITE) begin
            n_op.is_write = 1'b1;
            n_op.ra       = i_in.reg_index;
            n_op.imm      = i_in.reg_value;
        end else if (i_in.thumb) begin
            n_op.hit = 1'b1;
            if ((th & TH_LDPC_MASK) == TH_LDPC_MATCH) begin
                n_op.ra  = REG_PC;
                n_op.imm = th_sext;
            end else if ((th & TH_RR_MASK) == TH_RR_MATCH) begin
                n_op.ra      = {1'b0, th[5:3]};
                n_op.rb      = {1'b0, th[8:6]};
                n_op.off_sel = OFF_REG;
            end else if ((th & TH_RR_MASK) == TH_RRH_MATCH) begin
                n_op.ra      = {1'b0, th[5:3]};
                n_op.rb      = {2'b00, th[7:6]};
                n_op.off_sel = OFF_REG;
            end else if (((th & TH_IMW_MASK) == TH_IMW_MATCH) ||
                         ((th & TH_NIB_MASK) == TH_IMH_MATCH)) begin
                n_op.ra  = {1'b0, th[5:3]};
                n_op.imm = {25'd0, th[10:6], 2'b00};
            end else if ((th & TH_NIB_MASK) == TH_SPR_MATCH) begin
                n_op.ra  = REG_SP;
                n_op.imm = th_sext;
            end else if ((th & TH_PUSH_MASK) == TH_PUSH_MATCH) begin
                n_op.ra = REG_SP;
            end else if ((th & TH_NIB_MASK) == TH_LDM_MATCH) begin
                n_op.ra = {1'b0, th[10:8]};
            end else begin
                n_op.hit = 1'b0;
            end
        end else begin
            n_op.hit = 1'b1;
            n_op.ra  = w[19:16];
            n_op.rb  = w[3:0];
            n_op.add = w[23];
            if ((w & ARM_SWP_MASK) == ARM_SWP_MATCH) begin
                n_op.add = 1'b1;
            end else if ((w & ARM_LS_MASK) == ARM_LS_MATCH) begin
                // post-index: the base alone
                if (!w[24]) begin
                    n_op.add = 1'b1;
                end else if (w[25]) begin
                    n_op.off_sel   = OFF_SHF;
                    n_op.sh_type   = w[6:5];
                    n_op.sh_imm    = w[11:7];
                    n_op.rs        = w[11:8];
                    n_op.sh_bypass = (w[11:4] == SH_CTL_BYPASS);
                    n_op.use_rs    = w[4] && (w[11:4] != SH_CTL_BYPASS);
                end else begin
                    n_op.imm = {20'd0, w[11:0]};
                end
            end else if ((w & ARM_HW_MASK) == ARM_HWR_MATCH) begin
                n_op.off_sel = OFF_REG;
            end else if ((w & ARM_HW_MASK) == ARM_HWI_MATCH) begin
                n_op.imm = {24'd0, w[11:8], w[3:0]};
            end else if ((w & ARM_BLK_MASK) == ARM_BLK_MATCH) begin
                n_op.add = 1'b1;
            end else begin
                n_op.hit = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_in.ready) begin
            r_vld <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_op <= n_op;
        end
    end

    assign o_push_valid = r_vld;
    assign o_push_data  = r_op;

endmodule
`default_nettype wire

/* sv/afd_queue.sv */
// Short queue of classified words between the front and the back.
`timescale 1ns / 1ps
`default_nettype none
module afd_queue #(
    parameter int DEPTH = afd_pkg::AFD_QUEUE_DEPTH
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push_valid,
    output logic                  o_push_ready,
    input  wire afd_pkg::t_afd_op i_push_data,
    output logic                  o_pop_valid,
    input  wire logic             i_pop,
    output afd_pkg::t_afd_op      o_pop_data
);
    import afd_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    t_afd_op          r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_cnt;
    logic             push;
    logic             pop;

    assign o_push_ready = (r_cnt != CNT_FULL);
    assign o_pop_valid  = (r_cnt != '0);
    assign o_pop_data   = r_mem[r_rd_ptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = i_pop && o_pop_valid;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (pop && !push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

`ifndef SYNTHESIS
    a_cnt_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && !pop) |=> (r_cnt == $past(r_cnt) + 1'b1))
        else $error("queue count did not advance on push");
`endif

endmodule
`default_nettype wire

/* sv/afd_back.sv */
// Back end: register file, operand read, shifter and address adder.
`timescale 1ns / 1ps
`default_nettype none
module afd_back (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_q_valid,
    input  wire afd_pkg::t_afd_op i_head,
    output logic                  o_q_pop,
    afd_out_if.source             o_out
);
    import afd_pkg::*;

    function automatic logic [31:0] afd_shift(input logic [31:0] v,
                                              input logic [31:0] amt,
                                              input logic [1:0]  ty);
        logic        big;
        logic [4:0]  s;
        logic [63:0] dbl;
        logic [31:0] res;
        big = |amt[31:5];
        s   = amt[4:0];
        dbl = {v, v} >> s;
        case (ty)
            SH_LSL:  res = big ? '0 : (v << s);
            SH_LSR:  res = big ? '0 : (v >> s);
            SH_ASR:  res = big ? {32{v[31]}} : $unsigned($signed(v) >>> s);
            SH_ROR:  res = dbl[31:0];
            default: res = v;
        endcase
        return res;
    endfunction

    // register file and its read stage
    logic [31:0]          r_rf [REG_COUNT];
    logic [REG_COUNT-1:0] r_rf_vld;
    logic [31:0]          r_rd_a;
    logic [31:0]          r_rd_b;
    logic                 r_va;
    logic                 r_vb;
    logic [31:0]          r_rs;
    logic                 r_pre;
    logic                 r_r_vld;
    t_afd_op              r_r_op;

    // operand stage
    logic        r_x_vld;
    logic [31:0] r_x_base;
    logic [31:0] r_x_off;
    logic        r_x_add;
    logic        r_x_hit;

    // output register
    logic        r_o_vld;
    logic [31:0] r_o_addr;
    logic        r_o_matched;

    logic                 out_free;
    logic                 x_can;
    logic                 can_r;
    logic                 wr_en;
    logic                 pre_rd;
    logic                 load_r;
    logic [REG_IDX_W-1:0] a_addr;
    logic [31:0]          a_val;
    logic [31:0]          b_val;
    logic [31:0]          n_amt;
    logic [31:0]          n_x_off;
    logic [31:0]          n_o_addr;

    assign out_free = !r_o_vld || o_out.ready;
    assign x_can    = !r_x_vld || out_free;
    assign can_r    = !r_r_vld || x_can;

    assign wr_en  = i_q_valid && i_head.is_write;
    assign pre_rd = i_q_valid && can_r && !i_head.is_write && i_head.use_rs && !r_pre;
    assign load_r = i_q_valid && can_r && !i_head.is_write && !(i_head.use_rs && !r_pre);
    assign o_q_pop = wr_en || load_r;
    assign a_addr  = pre_rd ? i_head.rs : i_head.ra;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_rf[i_head.ra] <= i_head.imm;
        end
        if (pre_rd || load_r) begin
            r_rd_a <= r_rf[a_addr];
        end
        if (load_r) begin
            r_rd_b <= r_rf[i_head.rb];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rf_vld <= '0;
        end else if (wr_en) begin
            r_rf_vld[i_head.ra] <= 1'b1;
        end
    end

    // read stage: a register-amount shift reads Rs in a pre-read ahead of Rn and Rm
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pre   <= 1'b0;
            r_r_vld <= 1'b0;
        end else begin
            if (pre_rd) begin
                r_pre <= 1'b1;
            end else if (load_r) begin
                r_pre <= 1'b0;
            end
            if (can_r) begin
                r_r_vld <= load_r;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pre_rd || load_r) begin
            r_va <= r_rf_vld[a_addr];
        end
        if (load_r) begin
            r_vb   <= r_rf_vld[i_head.rb];
            r_r_op <= i_head;
            r_rs   <= r_va ? r_rd_a : '0;
        end
    end

    assign a_val = r_va ? r_rd_a : '0;
    assign b_val = r_vb ? r_rd_b : '0;
    assign n_amt = r_r_op.use_rs ? r_rs : {27'd0, r_r_op.sh_imm};

    always_comb begin
        case (r_r_op.off_sel)
            OFF_IMM: n_x_off = r_r_op.imm;
            OFF_REG: n_x_off = b_val;
            OFF_SHF: n_x_off = r_r_op.sh_bypass ? b_val
                                                : afd_shift(b_val, n_amt, r_r_op.sh_type);
            default: n_x_off = r_r_op.imm;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_vld <= 1'b0;
        end else if (x_can) begin
            r_x_vld <= r_r_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_r_vld && x_can) begin
            r_x_base <= a_val;
            r_x_off  <= n_x_off;
            r_x_add  <= r_r_op.add;
            r_x_hit  <= r_r_op.hit;
        end
    end

    assign n_o_addr = !r_x_hit ? '0 :
                      (r_x_add ? (r_x_base + r_x_off) : (r_x_base - r_x_off));

    // hold the word until the receiver takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else if (out_free) begin
            r_o_vld <= r_x_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_x_vld && out_free) begin
            r_o_addr    <= n_o_addr;
            r_o_matched <= r_x_hit;
        end
    end

    assign o_out.valid   = r_o_vld;
    assign o_out.address = r_o_addr;
    assign o_out.matched = r_o_matched;

`ifndef SYNTHESIS
    a_pre_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pre |-> (i_q_valid && !i_head.is_write && i_head.use_rs))
        else $error("Rs pre-read lost its queue head");

    a_pre_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pre |-> !r_r_vld)
        else $error("read stage loaded while Rs pre-read pending");

    a_rs_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (load_r && i_head.use_rs) |-> r_pre)
        else $error("register-shift word read before its Rs value");
`endif

endmodule
`default_nettype wire

/* sv/arm_fault_address_decoder_core.sv */
// Top level of the ARM/Thumb load/store fault address decoder.
//
// i_in carries words with valid/ready: opcode 0 writes reg_value into register
// reg_index of the 16-entry register file and gives no result; opcode 1 decodes
// instruction (ARM, or Thumb from bits 15:0 when thumb is set) and gives one
// word on o_out with the access address and the matched flag.
// Words leave o_out in the order they were accepted.
// A word passes the front register, queue, register file read, operand/shift stage
// and output register on its way to o_out.valid; an ARM register-amount shift
// first reads Rs through the single extra register file read before Rn and Rm.
// Throughput: one word per cycle while o_out.ready is high; a register-amount
// shift word also holds the read stage for its extra Rs read.
// Reset clears the register file to zero (per-entry valid bits), the queue and
// all pipeline valids. When o_out.ready is low the output register holds its
// word, the pipeline and queue fill behind it and i_in.ready drops once the
// front register cannot drain; nothing is dropped.
`timescale 1ns / 1ps
`default_nettype none
module arm_fault_address_decoder_core #(
    parameter int QUEUE_DEPTH = afd_pkg::AFD_QUEUE_DEPTH
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    afd_in_if.sink    i_in,
    afd_out_if.source o_out
);
    import afd_pkg::*;

    t_afd_op push_data;
    t_afd_op head;
    logic    push_valid;
    logic    push_ready;
    logic    q_valid;
    logic    q_pop;

    afd_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (i_in),
        .o_push_data  (push_data),
        .o_push_valid (push_valid),
        .i_push_ready (push_ready)
    );

    afd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .o_push_ready (push_ready),
        .i_push_data  (push_data),
        .o_pop_valid  (q_valid),
        .i_pop        (q_pop),
        .o_pop_data   (head)
    );

    afd_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_head    (head),
        .o_q_pop   (q_pop),
        .o_out     (o_out)
    );

endmodule
`default_nettype wire

/* sim/tb_arm_fault_address_decoder_core.sv */
// Self-checking testbench for the ARM/Thumb load/store fault address decoder core.
`timescale 1ns / 1ps
module tb_arm_fault_address_decoder_core;
    import afd_pkg::*;

    typedef struct packed {
        logic [31:0] address;
        logic        matched;
    } t_access;

    typedef enum logic [1:0] {SINK_FREE, SINK_PATTERN, SINK_RANDOM} t_sink_mode;

    localparam logic [12:0] READY_PATTERN = 13'b1101101110110;
    localparam int          MAX_REPORTS   = 10;

    logic i_clk;
    logic i_rst_n;

    afd_in_if  in_ch();
    afd_out_if out_ch();

    arm_fault_address_decoder_core DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    logic [31:0] gpr_shadow [REG_COUNT];
    t_access     pending_access_q [$];

    int unsigned burst_left;
    bit          gaps_on;
    t_sink_mode  sink_mode;
    int unsigned sink_hold_req;

    int unsigned n_writes;
    int unsigned n_arm;
    int unsigned n_thumb;
    int unsigned n_hits;
    int unsigned n_misses;
    int unsigned results_checked;
    int unsigned mismatch_count;
    int unsigned in_stall_cycles;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #400000;
        $display("arm_fault_address_decoder_core test failed");
        $finish;
    end

    // Address and match flag that a decode word should give, from the shadow registers.
    function automatic t_access predict_access(input logic [31:0] word, input logic thumb);
        t_access     res;
        logic [15:0] op16;
        logic [31:0] sext_imm;
        logic [31:0] base;
        logic [31:0] off;
        logic [31:0] rm_val;
        logic [31:0] amt;
        logic [7:0]  ctl;
        res.address = '0;
        res.matched = 1'b1;
        op16        = word[15:0];
        sext_imm    = {{24{op16[7]}}, op16[7:0]};
        base        = gpr_shadow[word[19:16]];
        off         = '0;
        if (thumb) begin
            if ((op16 & TH_LDPC_MASK) == TH_LDPC_MATCH)
                res.address = gpr_shadow[REG_PC] + sext_imm;
            else if ((op16 & TH_RR_MASK) == TH_RR_MATCH)
                res.address = gpr_shadow[{1'b0, op16[5:3]}] + gpr_shadow[{1'b0, op16[8:6]}];
            else if ((op16 & TH_RR_MASK) == TH_RRH_MATCH)
                res.address = gpr_shadow[{1'b0, op16[5:3]}] + gpr_shadow[{2'b00, op16[7:6]}];
            else if ((op16 & TH_IMW_MASK) == TH_IMW_MATCH
                     || (op16 & TH_NIB_MASK) == TH_IMH_MATCH)
                res.address = gpr_shadow[{1'b0, op16[5:3]}] + {25'b0, op16[10:6], 2'b00};
            else if ((op16 & TH_NIB_MASK) == TH_SPR_MATCH)
                res.address = gpr_shadow[REG_SP] + sext_imm;
            else if ((op16 & TH_PUSH_MASK) == TH_PUSH_MATCH)
                res.address = gpr_shadow[REG_SP];
            else if ((op16 & TH_NIB_MASK) == TH_LDM_MATCH)
                res.address = gpr_shadow[{1'b0, op16[10:8]}];
            else
                res.matched = 1'b0;
        end else begin
            if ((word & ARM_SWP_MASK) == ARM_SWP_MATCH) begin
                res.address = base;
            end else if ((word & ARM_LS_MASK) == ARM_LS_MATCH) begin
                if (!word[24]) begin
                    // post-index: the access goes to the base itself
                    res.address = base;
                end else begin
                    if (word[25]) begin
                        rm_val = gpr_shadow[word[3:0]];
                        ctl    = word[11:4];
                        // register amount uses the whole 32-bit value of Rs
                        amt    = ctl[0] ? gpr_shadow[ctl[7:4]] : {27'b0, ctl[7:3]};
                        if (ctl == SH_CTL_BYPASS) begin
                            off = rm_val;
                        end else begin
                            case (ctl[2:1])
                                SH_LSL: off = (amt >= 32) ? '0 : rm_val << amt;
                                SH_LSR: off = (amt >= 32) ? '0 : rm_val >> amt;
                                SH_ASR: begin
                                    if (amt >= 32)
                                        off = {32{rm_val[31]}};
                                    else
                                        off = $signed(rm_val) >>> amt;
                                end
                                default: off = 32'({rm_val, rm_val} >> amt[4:0]);
                            endcase
                        end
                    end else begin
                        off = {20'b0, word[11:0]};
                    end
                    res.address = word[23] ? base + off : base - off;
                end
            end else if ((word & ARM_HW_MASK) == ARM_HWR_MATCH) begin
                off         = gpr_shadow[word[3:0]];
                res.address = word[23] ? base + off : base - off;
            end else if ((word & ARM_HW_MASK) == ARM_HWI_MATCH) begin
                off         = {24'b0, word[11:8], word[3:0]};
                res.address = word[23] ? base + off : base - off;
            end else if ((word & ARM_BLK_MASK) == ARM_BLK_MATCH) begin
                res.address = base;
            end else begin
                res.matched = 1'b0;
            end
        end
        return res;
    endfunction

    // A mix of small and extreme values so that register shift amounts land below, at and above 32.
    function automatic logic [31:0] pick_reg_value();
        case ($urandom_range(0, 5))
            0:       return $urandom_range(0, 40);
            1:       return 32'hFFFF_FFFF;
            2:       return 32'h8000_0000 | $urandom;
            3:       return '0;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] shape_arm_word();
        logic [31:0] raw;
        raw = $urandom;
        case ($urandom_range(0, 9))
            0: raw = (raw & ~ARM_SWP_MASK) | ARM_SWP_MATCH;
            1, 2: begin
                raw     = (raw & ~ARM_LS_MASK) | ARM_LS_MATCH;
                raw[25] = 1'b0;
            end
            3, 4: begin
                raw     = (raw & ~ARM_LS_MASK) | ARM_LS_MATCH;
                raw[25] = 1'b1;
                raw[24] = ($urandom_range(0, 3) != 0);
                if ($urandom_range(0, 5) == 0)
                    raw[11:4] = SH_CTL_BYPASS;
            end
            5: raw = (raw & ~ARM_HW_MASK) | ARM_HWR_MATCH;
            6: raw = (raw & ~ARM_HW_MASK) | ARM_HWI_MATCH;
            7: raw = (raw & ~ARM_BLK_MASK) | ARM_BLK_MATCH;
            default: ;
        endcase
        return raw;
    endfunction

    function automatic logic [31:0] shape_thumb_word();
        logic [31:0] raw;
        logic [15:0] op16;
        raw  = $urandom;
        op16 = raw[15:0];
        case ($urandom_range(0, 9))
            0: op16 = (op16 & ~TH_LDPC_MASK) | TH_LDPC_MATCH;
            1: op16 = (op16 & ~TH_RR_MASK) | TH_RR_MATCH;
            2: op16 = (op16 & ~TH_RR_MASK) | TH_RRH_MATCH;
            3: op16 = (op16 & ~TH_IMW_MASK) | TH_IMW_MATCH;
            4: op16 = (op16 & ~TH_NIB_MASK) | TH_IMH_MATCH;
            5: op16 = (op16 & ~TH_NIB_MASK) | TH_SPR_MATCH;
            6: op16 = (op16 & ~TH_PUSH_MASK) | TH_PUSH_MATCH;
            7: op16 = (op16 & ~TH_NIB_MASK) | TH_LDM_MATCH;
            default: ;
        endcase
        return {raw[31:16], op16};
    endfunction

    // Offer one word, wait for the handshake and record what it should produce.
    task automatic send_word(input logic opc, input logic [3:0] idx, input logic [31:0] val,
                             input logic [31:0] instr, input logic thumb);
        t_access want;
        if (gaps_on && burst_left == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
            burst_left = $urandom_range(1, 12);
        end
        in_ch.valid       <= 1'b1;
        in_ch.opcode      <= opc;
        in_ch.reg_index   <= idx;
        in_ch.reg_value   <= val;
        in_ch.instruction <= instr;
        in_ch.thumb       <= thumb;
        do @(posedge i_clk); while (!in_ch.ready);
        if (burst_left != 0)
            burst_left--;
        if (opc == OPC_WRITE) begin
            gpr_shadow[idx] = val;
            n_writes++;
        end else begin
            want = predict_access(instr, thumb);
            pending_access_q.push_back(want);
            if (thumb)
                n_thumb++;
            else
                n_arm++;
            if (want.matched)
                n_hits++;
            else
                n_misses++;
        end
    endtask

    task automatic load_reg(input logic [3:0] idx, input logic [31:0] val);
        send_word(OPC_WRITE, idx, val, $urandom, 1'($urandom));
    endtask

    task automatic decode_arm_word(input logic [31:0] instr);
        send_word(OPC_DECODE, 4'($urandom), $urandom, instr, 1'b0);
    endtask

    task automatic decode_thumb_word(input logic [15:0] op16);
        logic [31:0] upper;
        upper = $urandom;
        send_word(OPC_DECODE, 4'($urandom), $urandom, {upper[31:16], op16}, 1'b1);
    endtask

    task automatic send_random_word();
        if ($urandom_range(0, 3) == 0)
            load_reg(4'($urandom), pick_reg_value());
        else if ($urandom_range(0, 1) == 0)
            send_word(OPC_DECODE, 4'($urandom), $urandom, shape_arm_word(), 1'b0);
        else
            send_word(OPC_DECODE, 4'($urandom), $urandom, shape_thumb_word(), 1'b1);
    endtask

    // Drop valid and hold until every outstanding result is back.
    task automatic wait_results_drained();
        in_ch.valid <= 1'b0;
        do @(posedge i_clk); while (pending_access_q.size() != 0);
    endtask

    task automatic test_reset_and_load();
        // cleared file: the base register reads as zero
        decode_arm_word(32'hE515_0FFF);
        load_reg(4'd0, 32'hFFFF_FFFF);
        load_reg(4'd1, 32'h8000_0000);
        load_reg(4'd2, 32'd33);
        load_reg(4'd3, 32'd4);
        load_reg(REG_SP, 32'h0000_1000);
    endtask

    task automatic test_arm_forms();
        decode_arm_word(32'hE101_0091);   // SWP
        decode_arm_word(32'hE491_0004);   // LDR post-index
        decode_arm_word(32'hE591_0FFF);   // LDR pre-index, add immediate
        decode_arm_word(32'hE191_00B0);   // LDRH register offset
        decode_arm_word(32'hE153_00BF);   // LDRH immediate, subtract
        decode_arm_word(32'hE893_FFFF);   // LDM
        decode_arm_word(32'hE000_0000);   // data processing, no match
    endtask

    task automatic test_shifter();
        decode_arm_word(32'hE793_00B1);   // bypass control byte
        decode_arm_word(32'hE713_0001);   // LSL #0, subtract
        decode_arm_word(32'hE793_0FC1);   // ASR #31
        decode_arm_word(32'hE793_0261);   // ROR #4
        decode_arm_word(32'hE793_0230);   // LSR by 33
        decode_arm_word(32'hE793_0251);   // ASR by 33
        decode_arm_word(32'hE793_0270);   // ROR by 33
    endtask

    task automatic test_thumb_forms();
        decode_thumb_word(16'h48FF);
        decode_thumb_word(16'h5058);
        decode_thumb_word(16'h52C0);
        decode_thumb_word(16'h7FD8);
        decode_thumb_word(16'h8848);
        decode_thumb_word(16'h9080);
        decode_thumb_word(16'hBDFF);
        decode_thumb_word(16'hC7FF);
        decode_thumb_word(16'h0000);
    endtask

    task automatic test_random_mix();
        for (int i = 0; i < 540; i++) begin
            // rotate receiver behaviour and sender gaps so each gets a clean stretch
            if (i % 135 == 0) begin
                sink_mode = t_sink_mode'((i / 135) % 3);
                gaps_on   = ((i / 135) % 2 == 0);
            end
            send_random_word();
        end
    endtask

    task automatic test_backpressure();
        gaps_on       = 1'b0;
        sink_mode     = SINK_FREE;
        sink_hold_req = 80;
        repeat (40) send_random_word();
        gaps_on       = 1'b1;
        sink_mode     = SINK_RANDOM;
    endtask

    task automatic test_sender_pause();
        repeat (15) send_random_word();
        wait_results_drained();
        repeat (15) send_random_word();
    endtask

    // Receiver: a long hold-off when asked, otherwise the current stall style.
    initial begin : sink_side
        int unsigned hold_left;
        int unsigned tick;
        hold_left = 0;
        tick      = 0;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            tick++;
            if (sink_hold_req != 0) begin
                hold_left     = sink_hold_req;
                sink_hold_req = 0;
            end
            if (hold_left != 0) begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end else begin
                case (sink_mode)
                    SINK_FREE:    out_ch.ready <= 1'b1;
                    SINK_PATTERN: out_ch.ready <= READY_PATTERN[4'(tick % 13)];
                    default:      out_ch.ready <= ($urandom_range(0, 3) != 0);
                endcase
            end
        end
    end

    always @(posedge i_clk) begin : result_check
        t_access want;
        if (in_ch.valid && !in_ch.ready)
            in_stall_cycles++;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            results_checked++;
            if (pending_access_q.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("unexpected result: address %h matched %b, none pending",
                             out_ch.address, out_ch.matched);
            end else begin
                want = pending_access_q.pop_front();
                if (out_ch.address !== want.address || out_ch.matched !== want.matched) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("mismatch: expected address %h matched %b, got %h matched %b",
                                 want.address, want.matched, out_ch.address, out_ch.matched);
                end
            end
        end
    end

    initial begin
        for (int r = 0; r < REG_COUNT; r++)
            gpr_shadow[r] = '0;
        burst_left      = 0;
        gaps_on         = 1'b1;
        sink_mode       = SINK_PATTERN;
        sink_hold_req   = 0;
        n_writes        = 0;
        n_arm           = 0;
        n_thumb         = 0;
        n_hits          = 0;
        n_misses        = 0;
        results_checked = 0;
        mismatch_count  = 0;
        in_stall_cycles = 0;
        i_rst_n           <= 1'b0;
        in_ch.valid       <= 1'b0;
        in_ch.opcode      <= OPC_WRITE;
        in_ch.reg_index   <= '0;
        in_ch.reg_value   <= '0;
        in_ch.instruction <= '0;
        in_ch.thumb       <= 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_and_load();
        test_arm_forms();
        test_shifter();
        test_thumb_forms();
        test_random_mix();
        test_backpressure();
        test_sender_pause();

        wait_results_drained();
        repeat (20) @(posedge i_clk);
        $display("Sent %0d writes, %0d decodes (%0d ARM, %0d Thumb; %0d matched, %0d not).",
                 n_writes, n_arm + n_thumb, n_arm, n_thumb, n_hits, n_misses);
        $display("Checked %0d results, %0d mismatches; input held off for %0d cycles.",
                 results_checked, mismatch_count, in_stall_cycles);
        if (mismatch_count == 0 && pending_access_q.size() == 0)
            $display("arm_fault_address_decoder_core test passed");
        else
            $display("arm_fault_address_decoder_core test failed");
        $finish;
    end
endmodule

/* files.f */
sv/afd_pkg.sv
sv/afd_in_if.sv
sv/afd_out_if.sv
sv/afd_front.sv
sv/afd_queue.sv
sv/afd_back.sv
sv/arm_fault_address_decoder_core.sv
sim/tb_arm_fault_address_decoder_core.sv
